/* hw/rtl/bfc_pkg.sv */
// Shared types and constants of the brightness fade controller.
package bfc_pkg;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_BRIGHT = 2'd1;
	localparam logic [1:0] ACT_POWER  = 2'd2;
	localparam logic [1:0] ACT_EFFECT = 2'd3;

	localparam logic [1:0] CAUSE_BRIGHT = 2'd0;
	localparam logic [1:0] CAUSE_POWER  = 2'd1;
	localparam logic [1:0] CAUSE_EFFECT = 2'd2;

	localparam logic [15:0] FADE_TICKS_RST = 16'd800;
	localparam logic [7:0]  LEVEL_MAX      = 8'd255;
	localparam logic [7:0]  HALF_POINT     = 8'd128;
	localparam logic [6:0]  HALF_MAX       = 7'd127;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic exec;
		logic div_step;
		logic phase;
		logic mul;
		logic fin;
		logic emit;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_tick;
		logic has_work;
		logic tick_done;
		logic div_last;
	} sts_t;

endpackage

/* hw/rtl/brightness_fade_controller_top.sv */
// Top level of the brightness fade controller.
//
// Input channel (in_valid/in_ready) carries one item per transfer: action 0 is
// a tick, 1 sets the brightness (level_in), 2 sets power (power_on), 3 asks for
// an effect change. Every item gives exactly one result transfer on the output
// channel (out_valid/out_ready): current level, active, switch_effect pulse,
// chosen level and power state.
// cfg_we writes cfg_data into the fade length register at once; write only
// while no item is in flight.
// A non-tick item, or a tick with nothing to fade, goes from EXEC straight to
// EMIT; a tick in a running fade first runs the 8-step restoring divider that
// forms elapsed*255/fade_ticks, then PHASE, MUL and FIN; a tick that ends a fade
// skips the divider. One item is in work at a time, so a new item can be taken
// in the cycle after the result is loaded.
// The result register holds one finished result; while the receiver stalls,
// the next item is still taken and worked on, and waits for the register.
// Reset: power on, all levels 0, no fade running, fade length 800 ticks.
module brightness_fade_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  level_in,
	input  logic        power_on,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  level_out,
	output logic        active,
	output logic        switch_effect,
	output logic [7:0]  chosen_out,
	output logic        power_out,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);

	bfc_pkg::cmd_t cmd;
	bfc_pkg::sts_t sts;

	bfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.action        (action),
		.level_in      (level_in),
		.power_on      (power_on),
		.cmd           (cmd),
		.sts           (sts),
		.level_out     (level_out),
		.active        (active),
		.switch_effect (switch_effect),
		.chosen_out    (chosen_out),
		.power_out     (power_out)
	);

	a_pulse_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && switch_effect |-> active)
		else $error("switch_effect without an active tick");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before result");

	a_no_div_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.div_step && !cmd.fin)
		else $error("datapath working while idle");

endmodule

/* hw/rtl/bfc_ctrl.sv */
// Sequencing state machine of the brightness fade controller.
module bfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bfc_pkg::sts_t sts,
	output bfc_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_PHASE,
		S_MUL,
		S_FIN,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.exec     = (state_q == S_EXEC);
		cmd.div_step = (state_q == S_DIV);
		cmd.phase    = (state_q == S_PHASE);
		cmd.mul      = (state_q == S_MUL);
		cmd.fin      = (state_q == S_FIN);
		cmd.emit     = (state_q == S_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_EMIT) && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (!sts.is_tick || !sts.has_work)
						state_q <= S_EMIT;
					else if (sts.tick_done)
						state_q <= S_PHASE;
					else
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (sts.div_last)
						state_q <= S_PHASE;
				end
				S_PHASE: state_q <= S_MUL;
				S_MUL:   state_q <= S_FIN;
				S_FIN:   state_q <= S_EMIT;
				S_EMIT: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/bfc_dpath.sv */
// Fade state, progress divider, interpolation and result registers.
module bfc_dpath (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data,
	input  logic [1:0]    action,
	input  logic [7:0]    level_in,
	input  logic          power_on,
	input  bfc_pkg::cmd_t cmd,
	output bfc_pkg::sts_t sts,
	output logic [7:0]    level_out,
	output logic          active,
	output logic          switch_effect,
	output logic [7:0]    chosen_out,
	output logic          power_out
);

	logic [15:0] fade_ticks_q;
	logic [1:0]  act_q;
	logic [7:0]  lvl_q;
	logic        pwr_in_q;

	logic        power_q;
	logic        effect_done_q;
	logic [7:0]  start_q;
	logic [7:0]  level_now_q;
	logic [7:0]  goal_q;
	logic [7:0]  chosen_q;
	logic [1:0]  cause_q;
	logic [15:0] elapsed_q;
	logic        running_q;
	logic        active_q;
	logic        pulse_q;

	logic [15:0] dur_q;
	logic [23:0] rem_q;
	logic [7:0]  quo_q;
	logic [2:0]  cnt_q;
	logic [7:0]  phase_q;
	logic [15:0] prod_q;
	logic        up_q;

	logic [7:0]  level_out_q;
	logic        active_out_q;
	logic        pulse_out_q;
	logic [7:0]  chosen_out_q;
	logic        power_out_q;

	logic [15:0] dur;
	logic [15:0] el_inc;
	logic [23:0] dsh;
	logic [6:0]  half_prog;
	logic [7:0]  half_phase;
	logic [7:0]  diff;
	logic        up;
	logic [16:0] q_sum;
	logic [7:0]  q255;

	assign dur    = (fade_ticks_q == '0) ? 16'd1 : fade_ticks_q;
	assign el_inc = (running_q && (elapsed_q < dur)) ? elapsed_q + 16'd1 : elapsed_q;
	assign dsh    = {8'd0, dur_q} << cnt_q;

	// x*255/127 for x up to 127 is 2x, plus one at x = 127
	assign half_prog  = quo_q[6:0];
	assign half_phase = {half_prog, 1'b0} + {7'd0, (half_prog == bfc_pkg::HALF_MAX)};

	assign up   = (goal_q >= start_q);
	assign diff = up ? goal_q - start_q : start_q - goal_q;

	// exact p/255 for p up to 255*255
	assign q_sum = {1'b0, prod_q} + 17'd1 + {9'd0, prod_q[15:8]};
	assign q255  = q_sum[15:8];

	assign sts.is_tick   = (act_q == bfc_pkg::ACT_TICK);
	assign sts.has_work  = running_q || (level_now_q != goal_q);
	assign sts.tick_done = !running_q || (el_inc >= dur);
	assign sts.div_last  = (cnt_q == '0);

	assign level_out     = level_out_q;
	assign active        = active_out_q;
	assign switch_effect = pulse_out_q;
	assign chosen_out    = chosen_out_q;
	assign power_out     = power_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_ticks_q  <= bfc_pkg::FADE_TICKS_RST;
			power_q       <= 1'b1;
			effect_done_q <= 1'b0;
			start_q       <= '0;
			level_now_q   <= '0;
			goal_q        <= '0;
			chosen_q      <= '0;
			cause_q       <= bfc_pkg::CAUSE_BRIGHT;
			elapsed_q     <= '0;
			running_q     <= 1'b0;
			active_q      <= 1'b0;
			pulse_q       <= 1'b0;
		end else begin
			if (cfg_we)
				fade_ticks_q <= cfg_data;
			if (cmd.load) begin
				active_q <= 1'b0;
				pulse_q  <= 1'b0;
			end
			if (cmd.exec) begin
				case (act_q)
					bfc_pkg::ACT_TICK: begin
						if (sts.has_work) begin
							elapsed_q <= el_inc;
							if (sts.tick_done)
								running_q <= 1'b0;
						end
					end
					bfc_pkg::ACT_BRIGHT: begin
						if (chosen_q != lvl_q) begin
							start_q   <= chosen_q;
							chosen_q  <= lvl_q;
							goal_q    <= lvl_q;
							cause_q   <= bfc_pkg::CAUSE_BRIGHT;
							elapsed_q <= '0;
							running_q <= 1'b1;
						end
					end
					bfc_pkg::ACT_POWER: begin
						if (power_q != pwr_in_q) begin
							power_q   <= pwr_in_q;
							start_q   <= pwr_in_q ? 8'd0 : chosen_q;
							goal_q    <= pwr_in_q ? chosen_q : 8'd0;
							cause_q   <= bfc_pkg::CAUSE_POWER;
							elapsed_q <= '0;
							running_q <= 1'b1;
						end
					end
					default: begin
						effect_done_q <= 1'b0;
						cause_q       <= bfc_pkg::CAUSE_EFFECT;
						elapsed_q     <= '0;
						running_q     <= 1'b1;
					end
				endcase
			end
			if (cmd.phase && (cause_q == bfc_pkg::CAUSE_EFFECT)) begin
				if (quo_q < bfc_pkg::HALF_POINT) begin
					start_q <= chosen_q;
					goal_q  <= '0;
				end else begin
					start_q <= '0;
					goal_q  <= chosen_q;
					if (!effect_done_q) begin
						pulse_q       <= 1'b1;
						effect_done_q <= 1'b1;
					end
				end
			end
			if (cmd.fin) begin
				level_now_q <= up_q ? start_q + q255 : start_q - q255;
				active_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			lvl_q    <= level_in;
			pwr_in_q <= power_on;
		end
		if (cmd.exec) begin
			// progress numerator elapsed*255, quotient fits 8 bits
			dur_q <= dur;
			rem_q <= {el_inc, 8'd0} - {8'd0, el_inc};
			quo_q <= sts.tick_done ? bfc_pkg::LEVEL_MAX : 8'd0;
			cnt_q <= 3'd7;
		end
		if (cmd.div_step) begin
			if (rem_q >= dsh) begin
				rem_q        <= rem_q - dsh;
				quo_q[cnt_q] <= 1'b1;
			end
			cnt_q <= cnt_q - 3'd1;
		end
		if (cmd.phase)
			phase_q <= (cause_q == bfc_pkg::CAUSE_EFFECT) ? half_phase : quo_q;
		if (cmd.mul) begin
			prod_q <= 16'(diff) * 16'(phase_q);
			up_q   <= up;
		end
		if (cmd.emit) begin
			level_out_q  <= level_now_q;
			active_out_q <= active_q;
			pulse_out_q  <= pulse_q;
			chosen_out_q <= chosen_q;
			power_out_q  <= power_q;
		end
	end

endmodule

/* sim/tb_brightness_fade_controller_top.sv */
// Self-checking testbench of the brightness fade controller: directed and random items.
`timescale 1ns / 100ps

module tb_brightness_fade_controller_top;

	localparam int unsigned IDLE_LIMIT  = 4000;
	localparam int unsigned HOLD_CYCLES = 250;
	localparam int unsigned ITEM_TARGET = 1550;

	typedef struct packed {
		logic [7:0] level;
		logic       active;
		logic       pulse;
		logic [7:0] chosen;
		logic       power;
	} fade_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [7:0]  level_in;
	logic        power_on;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  level_out;
	logic        active;
	logic        switch_effect;
	logic [7:0]  chosen_out;
	logic        power_out;
	logic        cfg_we;
	logic [15:0] cfg_data;

	// fader state as the block should hold it
	logic        f_power;
	logic        f_effect_done;
	logic [7:0]  f_start;
	logic [7:0]  f_level;
	logic [7:0]  f_goal;
	logic [7:0]  f_chosen;
	logic [1:0]  f_cause;
	logic [15:0] f_elapsed;
	logic        f_running;
	logic [15:0] f_fade_len;

	fade_result_t due_results[$];

	int unsigned fail_count;
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned pulses_seen;
	int unsigned fading_ticks;
	int unsigned lengths_used;
	bit          no_idle;
	bit          hold_off_req;

	brightness_fade_controller_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.level_in      (level_in),
		.power_on      (power_on),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.level_out     (level_out),
		.active        (active),
		.switch_effect (switch_effect),
		.chosen_out    (chosen_out),
		.power_out     (power_out),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] fade_blend(int unsigned from, int unsigned to,
			int unsigned phase);
		if (to >= from)
			return 8'(from + ((to - from) * phase) / 255);
		return 8'(from - ((from - to) * phase) / 255);
	endfunction

	// applies one item to the fader state and returns its result
	function automatic fade_result_t advance_fader(logic [1:0] act, logic [7:0] lvl,
			logic pwr);
		fade_result_t r;
		int unsigned  dur;
		int unsigned  prog;
		int unsigned  el;
		logic         done;
		r = '0;
		case (act)
			bfc_pkg::ACT_TICK: begin
				if (f_running || f_level != f_goal) begin
					dur = (f_fade_len == 16'd0) ? 1 : int'(f_fade_len);
					el = f_elapsed;
					if (f_running && el < dur)
						el++;
					f_elapsed = 16'(el);
					done = !f_running || el >= dur;
					prog = done ? 255 : (el * 255) / dur;
					if (done)
						f_running = 1'b0;
					if (f_cause == bfc_pkg::CAUSE_EFFECT) begin
						if (prog < 128) begin
							prog = (prog * 255) / 127;
							f_start = f_chosen;
							f_goal = 8'd0;
						end else begin
							if (!f_effect_done) begin
								r.pulse = 1'b1;
								f_effect_done = 1'b1;
							end
							prog = ((prog - 128) * 255) / 127;
							f_start = 8'd0;
							f_goal = f_chosen;
						end
					end
					f_level = fade_blend(f_start, f_goal, prog);
					r.active = 1'b1;
				end
			end
			bfc_pkg::ACT_BRIGHT: begin
				if (f_chosen != lvl) begin
					f_start = f_chosen;
					f_chosen = lvl;
					f_goal = lvl;
					f_cause = bfc_pkg::CAUSE_BRIGHT;
					f_elapsed = '0;
					f_running = 1'b1;
				end
			end
			bfc_pkg::ACT_POWER: begin
				if (f_power != pwr) begin
					f_power = pwr;
					f_start = pwr ? 8'd0 : f_chosen;
					f_goal = pwr ? f_chosen : 8'd0;
					f_cause = bfc_pkg::CAUSE_POWER;
					f_elapsed = '0;
					f_running = 1'b1;
				end
			end
			default: begin
				f_effect_done = 1'b0;
				f_cause = bfc_pkg::CAUSE_EFFECT;
				f_elapsed = '0;
				f_running = 1'b1;
			end
		endcase
		r.level = f_level;
		r.chosen = f_chosen;
		r.power = f_power;
		return r;
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [7:0] lvl, input logic pwr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		level_in <= lvl;
		power_on <= pwr;
		do @(posedge clk); while (!in_ready);
		due_results.push_back(advance_fader(act, lvl, pwr));
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_fade_length(input logic [15:0] len);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		f_fade_len = len;
		lengths_used++;
	endtask

	task automatic check_result();
		fade_result_t e;
		if (due_results.size() == 0) begin
			$error("result transfer with nothing outstanding");
			fail_count++;
			return;
		end
		e = due_results.pop_front();
		results_seen++;
		if (switch_effect === 1'b1)
			pulses_seen++;
		if (active === 1'b1)
			fading_ticks++;
		if (level_out !== e.level) begin
			$error("level_out exp %0d got %0d", e.level, level_out);
			fail_count++;
		end
		if (active !== e.active) begin
			$error("active exp %0d got %0d", e.active, active);
			fail_count++;
		end
		if (switch_effect !== e.pulse) begin
			$error("switch_effect exp %0d got %0d", e.pulse, switch_effect);
			fail_count++;
		end
		if (chosen_out !== e.chosen) begin
			$error("chosen_out exp %0d got %0d", e.chosen, chosen_out);
			fail_count++;
		end
		if (power_out !== e.power) begin
			$error("power_out exp %0d got %0d", e.power, power_out);
			fail_count++;
		end
	endtask

	initial begin : result_sink
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_result();
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// reset state, unchanged requests, plain brightness and power fades
	task automatic test_reset_and_unchanged();
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_POWER, 8'hFF, 1'b1);
		send_item(bfc_pkg::ACT_BRIGHT, 8'd0, 1'b1);
		send_item(bfc_pkg::ACT_BRIGHT, 8'd255, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_BRIGHT, 8'd255, 1'b1);
		send_item(bfc_pkg::ACT_POWER, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_POWER, 8'd0, 1'b1);
	endtask

	// shortest, zero and longest fade lengths, effect change with its pulse
	task automatic test_fade_length_extremes();
		set_fade_length(16'd1);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_EFFECT, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		set_fade_length(16'd0);
		send_item(bfc_pkg::ACT_BRIGHT, 8'd1, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_EFFECT, 8'd0, 1'b1);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		set_fade_length(16'hFFFF);
		send_item(bfc_pkg::ACT_BRIGHT, 8'd0, 1'b1);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
	endtask

	// shorten the fade below elapsed time while an effect fade runs
	task automatic test_midfade_length_change();
		set_fade_length(16'd4);
		send_item(bfc_pkg::ACT_BRIGHT, 8'd200, 1'b0);
		send_item(bfc_pkg::ACT_EFFECT, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
		set_fade_length(16'd2);
		send_item(bfc_pkg::ACT_TICK, 8'd0, 1'b0);
	endtask

	// receiver stops for a long stretch while items keep coming
	task automatic test_output_stall();
		set_fade_length(16'd6);
		no_idle = 1'b1;
		hold_off_req = 1'b1;
		send_item(bfc_pkg::ACT_BRIGHT, 8'h5A, 1'b0);
		repeat (12) send_item(bfc_pkg::ACT_TICK, 8'(($urandom)), 1'($urandom));
		send_item(bfc_pkg::ACT_EFFECT, 8'hA5, 1'b1);
		repeat (12) send_item(bfc_pkg::ACT_TICK, 8'(($urandom)), 1'($urandom));
		no_idle = 1'b0;
	endtask

	task automatic run_fade_sequence(input int unsigned len);
		int r;
		int unsigned n;
		r = $urandom_range(0, 99);
		if (r < 40)
			send_item(bfc_pkg::ACT_BRIGHT, 8'($urandom), 1'($urandom));
		else if (r < 60)
			send_item(bfc_pkg::ACT_POWER, 8'($urandom), ($urandom_range(0, 4) == 0) ?
				1'($urandom) : ~f_power);
		else if (r < 82)
			send_item(bfc_pkg::ACT_EFFECT, 8'($urandom), 1'($urandom));
		else
			send_item(2'($urandom), 8'($urandom), 1'($urandom));
		if (len > 40)
			n = $urandom_range(1, 40);
		else
			n = $urandom_range(len / 2, len + 3);
		repeat (n) send_item(bfc_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
	endtask

	task automatic test_random_fades();
		int r;
		int unsigned len;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				len = 1;
			else if (r < 15)
				len = 0;
			else if (r < 20)
				len = 2;
			else if (r < 24)
				len = 16'hFFFF;
			else if (r < 28)
				len = $urandom_range(256, 1000);
			else
				len = $urandom_range(3, 40);
			set_fade_length(16'(len));
			no_idle = ($urandom_range(0, 5) == 0);
			repeat ($urandom_range(3, 8)) run_fade_sequence(len);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = bfc_pkg::ACT_TICK;
		level_in = 8'd0;
		power_on = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 16'd0;
		fail_count = 0;
		items_sent = 0;
		results_seen = 0;
		pulses_seen = 0;
		fading_ticks = 0;
		lengths_used = 0;
		no_idle = 1'b0;
		hold_off_req = 1'b0;
		f_power = 1'b1;
		f_effect_done = 1'b0;
		f_start = 8'd0;
		f_level = 8'd0;
		f_goal = 8'd0;
		f_chosen = 8'd0;
		f_cause = bfc_pkg::CAUSE_BRIGHT;
		f_elapsed = 16'd0;
		f_running = 1'b0;
		f_fade_len = bfc_pkg::FADE_TICKS_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_unchanged();
		test_fade_length_extremes();
		test_midfade_length_change();
		test_output_stall();
		test_random_fades();

		drain();
		repeat (20) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			fail_count++;
		end
		$display("Covered %0d input transfers and %0d checked results over %0d fade lengths.",
			items_sent, results_seen, lengths_used);
		$display("Saw %0d fading ticks and %0d effect switch pulses.",
			fading_ticks, pulses_seen);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
